### hdl/apd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apd_pkg
// Types, codes and helper functions for the archive payload deframer.
// ----------------------------------------------------------------------------
package apd_pkg;

  // Parser phase, one-hot encoded.
  typedef enum logic [7:0] {
    PH_MAGIC = 8'b0000_0001,
    PH_COUNT = 8'b0000_0010,
    PH_PLEN  = 8'b0000_0100,
    PH_PATH  = 8'b0000_1000,
    PH_DLEN  = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_ERROR = 8'b1000_0000
  } phase_e;

  // Classification of each byte.
  typedef enum logic [2:0] {
    KIND_MAGIC   = 3'd0,
    KIND_COUNT   = 3'd1,
    KIND_PLEN    = 3'd2,
    KIND_PATH    = 3'd3,
    KIND_DLEN    = 3'd4,
    KIND_DATA    = 3'd5,
    KIND_IGNORED = 3'd6
  } kind_e;

  // Status codes, also used for the latched error.
  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TRAILING  = 3'd4
  } status_e;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Expected magic byte at a position; positions wrap modulo five.
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0, 3'd5: val = 8'h4D;
      3'd1, 3'd6: val = 8'h41;
      3'd2, 3'd7: val = 8'h4B;
      3'd3:       val = 8'h55;
      default:    val = 8'h01;
    endcase
    return val;
  endfunction

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### hdl/archive_payload_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_payload_deframer_top
// Deframes a length-prefixed record payload one byte per request, classifies
// each byte, tracks records and errors, and reports status and CRC-32.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | sink      | in_valid_i/in_stall_o | payload_byte_i, last_byte_i
//   out     | source    | out_valid_o/out_stall_i | byte_value_o .. final_res_o
//
// For each accepted request the parser state and CRC are updated in the
// cycle of acceptance and the result lands in a single output register, so a
// new byte is taken every cycle while the output side keeps up.
// The output register is the only buffer; when it holds a result that is
// stalled, in_stall_o is raised in the same cycle.
// Reset clears the parser to the magic phase and the CRC to all ones; the
// same state is restored after every final byte, ready for the next payload.
//
module archive_payload_deframer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           payload_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           byte_value_o,
  output logic [2:0]           byte_kind_o,
  output logic [31:0]          record_index_o,
  output logic                 field_end_o,
  output logic [2:0]           status_o,
  output logic [31:0]          crc_value_o,
  output logic                 final_res_o
);
  import apd_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [31:0] left_q, left_d;
  logic [31:0] rec_q, rec_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] crc_q, crc_d;
  status_e     err_q, err_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  value_q;
  kind_e       kind_q, kind_d;
  logic [31:0] index_q;
  logic        fend_q, fend_d;
  status_e     status_q, status_d;
  logic [31:0] crcout_q, crcout_d;
  logic        final_q;

  logic        accept;
  logic [31:0] word_new;
  logic        word_full;
  logic [31:0] bytes_dec;
  logic [31:0] crc_next;

  // The output register is free when empty or being drained this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign crc_next  = crc_byte(crc_q, payload_byte_i);
  assign word_new  = word_q | ({24'd0, payload_byte_i} << {pos_q[1:0], 3'b000});
  assign word_full = (pos_q >= 3'd3);
  assign bytes_dec = bytes_q - 32'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    word_d   = word_q;
    left_d   = left_q;
    rec_d    = rec_q;
    bytes_d  = bytes_q;
    err_d    = err_q;
    crc_d    = crc_next;
    kind_d   = KIND_IGNORED;
    fend_d   = 1'b0;
    status_d = err_q;
    crcout_d = 32'd0;

    unique case (phase_q)
      PH_MAGIC: begin
        kind_d = KIND_MAGIC;
        if (payload_byte_i != magic_byte(pos_q)) begin
          err_d   = ST_BAD_MAGIC;
          phase_d = PH_ERROR;
        end else if (pos_q >= 3'd4) begin
          pos_d   = 3'd0;
          word_d  = 32'd0;
          phase_d = PH_COUNT;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      PH_COUNT: begin
        kind_d = KIND_COUNT;
        if (word_full) begin
          pos_d   = 3'd0;
          left_d  = word_new;
          word_d  = 32'd0;
          phase_d = (word_new == 32'd0) ? PH_DONE : PH_PLEN;
        end else begin
          pos_d  = pos_q + 3'd1;
          word_d = word_new;
        end
      end
      PH_PLEN: begin
        kind_d = KIND_PLEN;
        if (word_full) begin
          pos_d   = 3'd0;
          bytes_d = word_new;
          word_d  = 32'd0;
          phase_d = (word_new == 32'd0) ? PH_DLEN : PH_PATH;
        end else begin
          pos_d  = pos_q + 3'd1;
          word_d = word_new;
        end
      end
      PH_PATH: begin
        kind_d  = KIND_PATH;
        bytes_d = bytes_dec;
        if (bytes_dec == 32'd0) begin
          fend_d  = 1'b1;
          phase_d = PH_DLEN;
        end
      end
      PH_DLEN: begin
        kind_d = KIND_DLEN;
        if (word_full) begin
          pos_d   = 3'd0;
          bytes_d = word_new;
          word_d  = 32'd0;
          if (word_new == 32'd0) begin
            // An empty data field closes the record at once.
            rec_d   = rec_q + 32'd1;
            left_d  = left_q - 32'd1;
            phase_d = (left_q == 32'd1) ? PH_DONE : PH_PLEN;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          pos_d  = pos_q + 3'd1;
          word_d = word_new;
        end
      end
      PH_DATA: begin
        kind_d  = KIND_DATA;
        bytes_d = bytes_dec;
        if (bytes_dec == 32'd0) begin
          fend_d  = 1'b1;
          rec_d   = rec_q + 32'd1;
          left_d  = left_q - 32'd1;
          phase_d = (left_q == 32'd1) ? PH_DONE : PH_PLEN;
        end
      end
      PH_DONE: begin
        err_d   = ST_TRAILING;
        phase_d = PH_ERROR;
      end
      default: begin
      end
    endcase

    status_d = err_d;
    if (last_byte_i) begin
      if (err_d == ST_BUSY) begin
        status_d = (phase_d == PH_DONE) ? ST_OK : ST_TRUNCATED;
      end
      crcout_d = ~crc_next;
      // The final byte returns the parser to its reset state.
      phase_d = PH_MAGIC;
      pos_d   = 3'd0;
      word_d  = 32'd0;
      left_d  = 32'd0;
      bytes_d = 32'd0;
      err_d   = ST_BUSY;
      crc_d   = CRC_INIT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      pos_q       <= 3'd0;
      word_q      <= 32'd0;
      left_q      <= 32'd0;
      rec_q       <= 32'd0;
      bytes_q     <= 32'd0;
      crc_q       <= CRC_INIT;
      err_q       <= ST_BUSY;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        word_q  <= word_d;
        left_q  <= left_d;
        // The record index is reported after this byte's update.
        rec_q   <= last_byte_i ? 32'd0 : rec_d;
        bytes_q <= bytes_d;
        crc_q   <= crc_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= payload_byte_i;
      kind_q   <= kind_d;
      index_q  <= rec_d;
      fend_q   <= fend_d;
      status_q <= status_d;
      crcout_q <= crcout_d;
      final_q  <= last_byte_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = value_q;
  assign byte_kind_o    = kind_q;
  assign record_index_o = index_q;
  assign field_end_o    = fend_q;
  assign status_o       = status_q;
  assign crc_value_o    = crcout_q;
  assign final_res_o    = final_q;

endmodule
